// ===== sv/ccsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the CV/CC supply regulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ccsr_pkg;

  localparam int RING_DEPTH = 4;
  localparam int RING_AW = $clog2(RING_DEPTH);

  localparam int SAMPLE_W = 10;
  localparam int VOLT_W = 11;
  localparam int DAC_W = 12;
  localparam int FAN_W = 11;
  localparam int DIVISOR_W = 8;
  localparam int HOLD_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam int DIV_STEPS = SAMPLE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DAC_W-1:0] DAC_MAX = 12'hFFF;
  localparam logic [DAC_W-1:0] DAC_FLOOR = 12'd400;
  localparam logic [HOLD_W-1:0] SC_HOLD = 6'd20;
  localparam logic [HOLD_W-1:0] CC_HOLD = 6'd40;
  localparam logic signed [12:0] STEP_BOOST = 13'sd20;
  localparam logic signed [12:0] STEP_CUT = -13'sd20;
  localparam logic signed [12:0] DITHER_HIGH = 13'sd5;
  localparam logic signed [12:0] DITHER_LOW = -13'sd5;
  localparam logic signed [10:0] CC_DEADBAND = -11'sd4;
  localparam logic signed [10:0] FAN_DEADBAND = 11'sd7;
  localparam logic [VOLT_W-1:0] VOLT_RESET = 11'd20;
  localparam logic [SAMPLE_W-1:0] TEMP_RESET = 10'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_CURRENT = 3'd0,
    CFG_TARGET_VOLTAGE = 3'd1,
    CFG_FAN_COOL_LEVEL = 3'd2,
    CFG_FAN_DIVISOR = 3'd3,
    CFG_SHORT_LEVEL = 3'd4
  } cfg_index_t;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
  } ccsr_cmd_t;

  typedef struct packed {
    logic need_div;
  } ccsr_status_t;

endpackage

// ===== sv/ccsr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the CV/CC supply regulator.
// Sequences capture, update, fan divide and result transfer; uses ccsr_pkg.
module ccsr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ccsr_pkg::ccsr_status_t status,
  output ccsr_pkg::ccsr_cmd_t   cmd
);
  import ccsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [DIV_CNT_W-1:0] div_count, div_count_next;

  always_comb begin
    state_next = state;
    div_count_next = div_count;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_div) begin
          div_count_next = DIV_CNT_W'(DIV_STEPS - 1);
          state_next = S_DIVIDE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        div_count_next = div_count - 1'b1;
        if (div_count == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      div_count <= div_count_next;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

endmodule

// ===== sv/ccsr_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the CV/CC supply regulator: configuration, channel state,
// oversampling ring, CV/CC loop with dither, and a restoring fan divider. Uses ccsr_pkg.
module ccsr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  ccsr_pkg::ccsr_cmd_t                 cmd,
  output ccsr_pkg::ccsr_status_t              status,
  input  logic                                cfg_write,
  input  logic [ccsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccsr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                opcode,
  input  logic [ccsr_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic [ccsr_pkg::DAC_W-1:0]          dac_value,
  output logic                                dac_write,
  output logic [ccsr_pkg::FAN_W-1:0]          fan_speed,
  output logic                                fan_write,
  output logic                                alarm_led,
  output logic                                current_limit_mode,
  output logic [1:0]                          mux_select
);
  import ccsr_pkg::*;

  logic [SAMPLE_W-1:0] target_current;
  logic [VOLT_W-1:0] target_voltage;
  logic [SAMPLE_W-1:0] fan_cool_level;
  logic [DIVISOR_W-1:0] fan_divisor;
  logic [SAMPLE_W-1:0] short_level;

  logic op_q;
  logic [SAMPLE_W-1:0] sample_q;

  logic [1:0] channel;
  logic [RING_AW-1:0] ring_pos;
  logic [SAMPLE_W-1:0] voltage_ring [RING_DEPTH];
  logic [VOLT_W-1:0] voltage_reading;
  logic [SAMPLE_W-1:0] current_reading;
  logic [SAMPLE_W-1:0] temp_reading;
  logic [HOLD_W-1:0] hold;
  logic signed [1:0] dither;
  logic [DAC_W-1:0] dac;
  logic led;

  logic res_wrote;
  logic res_fan_en;
  logic res_fan_write;
  logic [SAMPLE_W-1:0] quo;
  logic [DIVISOR_W-1:0] rem;

  logic [1:0] channel_next;
  logic [SAMPLE_W+RING_AW-1:0] ring_sum;
  logic [VOLT_W:0] volt_pair;

  logic signed [10:0] fan_diff;
  logic signed [10:0] cur_err;
  logic signed [12:0] volt_err;
  logic signed [12:0] step;
  logic [HOLD_W-1:0] hold_tick;
  logic signed [2:0] dith_sum;
  logic signed [1:0] dither_tick;
  logic signed [1:0] fine_step;
  logic signed [13:0] dac_sum;
  logic [DAC_W-1:0] dac_tick;
  logic led_tick;
  logic tick_write;

  logic [DIVISOR_W-1:0] div_eff;
  logic [DIVISOR_W:0] rem_shift;
  logic rem_fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_current <= '0;
      target_voltage <= '0;
      fan_cool_level <= '0;
      fan_divisor <= 8'd1;
      short_level <= 10'd1023;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_CURRENT: target_current <= cfg_data[SAMPLE_W-1:0];
        CFG_TARGET_VOLTAGE: target_voltage <= cfg_data[VOLT_W-1:0];
        CFG_FAN_COOL_LEVEL: fan_cool_level <= cfg_data[SAMPLE_W-1:0];
        CFG_FAN_DIVISOR:    fan_divisor <= cfg_data[DIVISOR_W-1:0];
        CFG_SHORT_LEVEL:    short_level <= cfg_data[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    channel_next = (channel == 2'd2) ? 2'd0 : channel + 2'd1;
    ring_sum = '0;
    for (int k = 0; k < RING_DEPTH; k++) begin
      if (ring_pos == RING_AW'(k)) begin
        ring_sum = ring_sum + {{RING_AW{1'b0}}, sample_q};
      end else begin
        ring_sum = ring_sum + {{RING_AW{1'b0}}, voltage_ring[k]};
      end
    end
    volt_pair = {1'b0, ring_sum[SAMPLE_W+RING_AW-1:1]} + {1'b0, voltage_reading};
  end

  always_comb begin
    fan_diff = $signed({1'b0, fan_cool_level}) - $signed({1'b0, temp_reading});
    cur_err = $signed({1'b0, target_current}) - $signed({1'b0, current_reading});
    volt_err = 13'sd1 + $signed({2'b0, target_voltage}) - $signed({2'b0, voltage_reading});
    hold_tick = hold;
    step = '0;
    if (cur_err[10]) begin
      step = (cur_err > CC_DEADBAND) ? 13'sd0 : {{2{cur_err[10]}}, cur_err};
      hold_tick = CC_HOLD;
      if (voltage_reading > target_voltage) begin
        step = STEP_CUT;
        hold_tick = '0;
      end
    end else begin
      step = volt_err;
      if (hold != '0) begin
        hold_tick = hold - 1'b1;
        if (hold_tick[2:0] == 3'd0) begin
          if (step > 13'sd0) begin
            step = STEP_BOOST;
          end
        end else begin
          step = '0;
        end
      end
    end
    tick_write = (step != 13'sd0);

    dith_sum = {dither[1], dither};
    dither_tick = dither;
    fine_step = '0;
    if (step > DITHER_LOW && step < DITHER_HIGH) begin
      if (step > 13'sd0) begin
        dith_sum = {dither[1], dither} + 3'sd1;
        if (dith_sum > 3'sd1) begin
          fine_step = 2'sd1;
          dither_tick = '0;
        end else begin
          dither_tick = dith_sum[1:0];
        end
      end else if (step < 13'sd0) begin
        dith_sum = {dither[1], dither} - 3'sd1;
        if (dith_sum < -3'sd1) begin
          fine_step = -2'sd1;
          dither_tick = '0;
        end else begin
          dither_tick = dith_sum[1:0];
        end
      end
    end else begin
      fine_step = step[12] ? -2'sd1 : 2'sd1;
    end

    dac_sum = $signed({2'b0, dac}) + {{12{fine_step[1]}}, fine_step};
    if (!dac_sum[13] && dac_sum[12]) begin
      dac_tick = DAC_MAX;
      led_tick = 1'b1;
    end else if (dac_sum[13] || dac_sum[12:0] < {1'b0, DAC_FLOOR}) begin
      dac_tick = DAC_FLOOR;
      led_tick = 1'b1;
    end else begin
      dac_tick = dac_sum[DAC_W-1:0];
      led_tick = 1'b0;
    end
  end

  assign status.need_div = op_q && (fan_diff > FAN_DEADBAND);

  assign div_eff = (fan_divisor == '0) ? DIVISOR_W'(1) : fan_divisor;
  assign rem_shift = {rem, quo[SAMPLE_W-1]};
  assign rem_fits = (rem_shift >= {1'b0, div_eff});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= opcode;
      sample_q <= adc_sample;
    end
    if (cmd.exec && status.need_div) begin
      quo <= fan_diff[SAMPLE_W-1:0];
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_fits) begin
        rem <= DIVISOR_W'(rem_shift - {1'b0, div_eff});
        quo <= {quo[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DIVISOR_W-1:0];
        quo <= {quo[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= '0;
      ring_pos <= '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        voltage_ring[k] <= '0;
      end
      voltage_reading <= VOLT_RESET;
      current_reading <= '0;
      temp_reading <= TEMP_RESET;
      hold <= 6'd1;
      dither <= '0;
      dac <= '0;
      led <= 1'b0;
      res_wrote <= 1'b0;
      res_fan_en <= 1'b0;
      res_fan_write <= 1'b0;
    end else if (cmd.exec) begin
      if (op_q == OP_TICK) begin
        hold <= hold_tick;
        res_wrote <= tick_write;
        res_fan_en <= status.need_div;
        res_fan_write <= 1'b1;
        if (tick_write) begin
          dac <= dac_tick;
          dither <= dither_tick;
          led <= led_tick;
        end else begin
          led <= 1'b0;
        end
      end else begin
        channel <= channel_next;
        res_wrote <= 1'b0;
        res_fan_en <= 1'b0;
        res_fan_write <= 1'b0;
        unique case (channel_next)
          2'd0: begin
            voltage_ring[ring_pos] <= sample_q;
            ring_pos <= ring_pos + 1'b1;
            voltage_reading <= volt_pair[VOLT_W:1];
          end
          2'd1: begin
            temp_reading <= sample_q;
          end
          default: begin
            current_reading <= sample_q;
            if (sample_q > short_level) begin
              dac <= DAC_FLOOR;
              hold <= SC_HOLD;
              res_wrote <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign dac_value = dac;
  assign dac_write = res_wrote;
  assign fan_speed = res_fan_en ? ({1'b0, quo} + FAN_W'(1)) : '0;
  assign fan_write = res_fan_write;
  assign alarm_led = led;
  assign current_limit_mode = (hold != '0);
  assign mux_select = channel + 2'd1;

endmodule

// ===== sv/cv_cc_supply_regulator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the CV/CC supply regulator: controller plus datapath.
// An item is loaded in S_IDLE, updated in S_EXEC, and its result is shown in S_DONE;
// input ready returns only once the result is taken, so a new item is not taken before the
// last one is through; ticks that drive the fan first pass through S_DIVIDE for the
// bit-serial fan divider, and a waiting result holds off the input.
// Synchronous active-high reset restores all but the captured item and divider registers.
module cv_cc_supply_regulator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [ccsr_pkg::SAMPLE_W-1:0]    adc_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ccsr_pkg::DAC_W-1:0]       dac_value,
  output logic                             dac_write,
  output logic [ccsr_pkg::FAN_W-1:0]       fan_speed,
  output logic                             fan_write,
  output logic                             alarm_led,
  output logic                             current_limit_mode,
  output logic [1:0]                       mux_select,
  input  logic                             cfg_write,
  input  logic [ccsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccsr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ccsr_pkg::*;

  ccsr_cmd_t cmd;
  ccsr_status_t status;

  ccsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ccsr_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .opcode             (opcode),
    .adc_sample         (adc_sample),
    .dac_value          (dac_value),
    .dac_write          (dac_write),
    .fan_speed          (fan_speed),
    .fan_write          (fan_write),
    .alarm_led          (alarm_led),
    .current_limit_mode (current_limit_mode),
    .mux_select         (mux_select)
  );

  // A new item is never taken while a result is waiting.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !out_valid)
    else $error("result presented in the cycle after the input transfer");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fan_write) |-> (fan_speed == '0))
    else $error("fan level driven on a sample item");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && dac_write && !fan_write) |-> (dac_value == DAC_FLOOR))
    else $error("short-circuit cutback did not set the DAC floor");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && dac_write) |-> (dac_value >= DAC_FLOOR))
    else $error("DAC written below its floor");

endmodule
